// ===== sv/elementwise_activation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Elementwise activation unit assertion macros
// Shared concurrent-assertion forms, sampled on clk, reset active low.
// ----------------------------------------------------------------------------
`ifndef ELEMENTWISE_ACTIVATION_UNIT_DEFINES_SVH
`define ELEMENTWISE_ACTIVATION_UNIT_DEFINES_SVH

// Same-cycle implication, off while in reset
`define EAU_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define EAU_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset
`define EAU_ASSERT_RST(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/eau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_pkg
// Types, constants and table builders shared by the activation unit.
// ----------------------------------------------------------------------------
package eau_pkg;

  // Element width, fixed by the data format
  localparam int DATA_W = 16;

  // Defaults for the top-level parameters
  localparam int DEF_FRAC_BITS = 12;
  localparam int DEF_SEGMENTS  = 32;

  // Pipeline depth: front, table read, multiply, output register
  localparam int NSTAGE = 4;

  // Configuration port
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 3;
  localparam int CFG_IDX_LSB = 2;
  localparam logic REG_MODE  = 1'b0;

  // Hard sigmoid divide by five: reciprocal multiply, exact for numerators below 2^HS_VW
  localparam int HS_VW = DATA_W + 1;
  localparam int HS_S  = HS_VW + 3;
  localparam int HS_M  = ((1 << HS_S) + 4) / 5;
  localparam int HS_MW = HS_S - 2;

  // Table construction precision
  localparam logic [63:0] ONE_Q = 64'h4000_0000_0000_0000;
  localparam int SERIES_TERMS = 24;

  typedef enum logic [1:0] {
    MODE_RELU = 2'd0,
    MODE_HSIG = 2'd1,
    MODE_SIG  = 2'd2,
    MODE_TANH = 2'd3
  } mode_t;

  // Load strobes, one per pipeline stage
  typedef struct packed {
    logic s1_ld;
    logic s2_ld;
    logic s3_ld;
    logic s4_ld;
  } stage_ld_t;

  // Truncating Q2.62 multiply
  function automatic logic [63:0] eau_qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring unsigned divide, used only while building constant tables
  function automatic logic [63:0] eau_udiv(logic [63:0] num, logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // One table entry at segment end k: sigmoid or tanh, rounded to fb fraction bits
  function automatic logic [DATA_W-1:0] eau_tab_entry(int segs, int fb, int k,
                                                       logic is_tanh);
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] r8;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] nq;
    logic [63:0] dq;
    term = ONE_Q;
    r    = ONE_Q;
    // exp(-1/segs) by its series
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = eau_udiv(term, 64'(segs) * 64'(n));
      if (n % 2 == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    // step of one segment: exp(-8/segs)
    r8 = eau_qmul(r, r);
    r8 = eau_qmul(r8, r8);
    r8 = eau_qmul(r8, r8);
    p = ONE_Q;
    for (int j = 0; j < k; j++) begin
      p = eau_qmul(p, r8);
    end
    q = eau_qmul(p, p);
    if (is_tanh) begin
      num = ONE_Q - q;
      den = ONE_Q + q;
    end else begin
      num = ONE_Q;
      den = ONE_Q + p;
    end
    nq = num >> 22;
    dq = den >> 22;
    if (dq == 64'd0) begin
      dq = 64'd1;
    end
    return DATA_W'(eau_udiv((nq << (fb + 1)) + dq, dq << 1));
  endfunction

endpackage

// ===== sv/elementwise_activation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementwise_activation_unit
// ReLU, hard sigmoid, sigmoid and tanh on a stream of signed fixed-point words.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_ready       in_x, in_last_in
//  out      out_valid / out_ready     out_y, out_last_out
//  cfg      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
//  One word per cycle sustained while out_ready is high; an accepted word passes through
//  four register stages: segment front, ROM read, slope multiply, output register.
//  Reset clears the stage valid bits and sets mode to ReLU.
//  A stalled output holds its word; ready ripples back, so bubbles keep filling.
//  Sigmoid and tanh tables are constants computed at elaboration.
// ----------------------------------------------------------------------------
module elementwise_activation_unit import eau_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int SEGMENTS  = DEF_SEGMENTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_x,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_y,
  output logic                     out_last_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int IW = $clog2(SEGMENTS + 1);

  mode_t     mode;
  stage_ld_t ld;

  logic signed [DATA_W-1:0] x1;
  logic                     last1;
  logic [IW-1:0]            k1;
  logic [FRAC_BITS+3:0]     rem1;
  logic [HS_VW-1:0]         hsv1;
  logic                     hslo1;
  logic                     hshi1;

  logic signed [DATA_W-1:0] x3;
  logic                     last3;
  logic                     hslo3;
  logic                     hshi3;
  logic [FRAC_BITS:0]       hsq3;
  logic [FRAC_BITS:0]       lo3;
  logic [2*FRAC_BITS+4:0]   prod3;
  logic                     dneg3;

  eau_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  eau_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ld        (ld)
  );

  eau_seg_front #(
    .FRAC_BITS (FRAC_BITS),
    .SEGMENTS  (SEGMENTS)
  ) u_front (
    .clk     (clk),
    .ld      (ld.s1_ld),
    .in_x    (in_x),
    .in_last (in_last_in),
    .x_r     (x1),
    .last_r  (last1),
    .k_r     (k1),
    .rem_r   (rem1),
    .hsv_r   (hsv1),
    .hslo_r  (hslo1),
    .hshi_r  (hshi1)
  );

  eau_interp #(
    .FRAC_BITS (FRAC_BITS),
    .SEGMENTS  (SEGMENTS)
  ) u_interp (
    .clk     (clk),
    .ld2     (ld.s2_ld),
    .ld3     (ld.s3_ld),
    .mode    (mode),
    .x1      (x1),
    .last1   (last1),
    .k1      (k1),
    .rem1    (rem1),
    .hsv1    (hsv1),
    .hslo1   (hslo1),
    .hshi1   (hshi1),
    .x3_r    (x3),
    .last3_r (last3),
    .hslo3_r (hslo3),
    .hshi3_r (hshi3),
    .hsq3_r  (hsq3),
    .lo3_r   (lo3),
    .prod3_r (prod3),
    .dneg3_r (dneg3)
  );

  eau_out_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk          (clk),
    .ld           (ld.s4_ld),
    .mode         (mode),
    .x3           (x3),
    .last3        (last3),
    .hslo3        (hslo3),
    .hshi3        (hshi3),
    .hsq3         (hsq3),
    .lo3          (lo3),
    .prod3        (prod3),
    .dneg3        (dneg3),
    .out_y        (out_y),
    .out_last_out (out_last_out)
  );

endmodule

// ===== sv/eau_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_cfg_regs
// APB-style register file holding the activation mode.
// ----------------------------------------------------------------------------
module eau_cfg_regs import eau_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output mode_t             mode
);

  mode_t mode_r;
  logic  reg_idx;
  logic  wr_en;

  assign reg_idx = paddr[CFG_AW-1:CFG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign mode    = mode_r;

  // Write the mode register, drop writes to other indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RELU;
    end else if (wr_en && (reg_idx == REG_MODE)) begin
      mode_r <= mode_t'(pwdata[1:0]);
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODE) begin
      prdata = {{(CFG_DW-2){1'b0}}, mode_r};
    end
  end

endmodule

// ===== sv/eau_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_pipe_ctrl
// Valid bits and per-stage load strobes; ready ripples back through bubbles.
// ----------------------------------------------------------------------------
module eau_pipe_ctrl import eau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output stage_ld_t ld
);

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] rdy;
  logic [NSTAGE-1:0] feed;

  // A stage takes a word when it is empty or its own word moves on
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    feed[0] = in_valid;
    for (int i = 1; i < NSTAGE; i++) begin
      feed[i] = vld_r[i-1];
    end
    for (int i = 0; i < NSTAGE; i++) begin
      vld_nxt[i] = rdy[i] ? feed[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload only where a valid word arrives
  assign ld.s1_ld = rdy[0] && feed[0];
  assign ld.s2_ld = rdy[1] && feed[1];
  assign ld.s3_ld = rdy[2] && feed[2];
  assign ld.s4_ld = rdy[3] && feed[3];

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTAGE-1];

endmodule

// ===== sv/eau_seg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_seg_front
// Stage 1: magnitude, table segment and remainder, hard sigmoid numerator.
// ----------------------------------------------------------------------------
module eau_seg_front import eau_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int SEGMENTS  = DEF_SEGMENTS
) (
  input  logic                            clk,
  input  logic                            ld,
  input  logic signed [DATA_W-1:0]        in_x,
  input  logic                            in_last,
  output logic signed [DATA_W-1:0]        x_r,
  output logic                            last_r,
  output logic [$clog2(SEGMENTS+1)-1:0]   k_r,
  output logic [FRAC_BITS+3:0]            rem_r,
  output logic [HS_VW-1:0]                hsv_r,
  output logic                            hslo_r,
  output logic                            hshi_r
);

  localparam int IW     = $clog2(SEGMENTS + 1);
  localparam int PW     = DATA_W + IW;
  localparam int SH     = FRAC_BITS + 3;
  localparam int RW     = SH + 1;
  localparam int HW     = DATA_W + 2;
  localparam int HALF   = 1 << (FRAC_BITS - 1);
  localparam int HS_LIM = 5 * HALF;
  localparam logic [RW-1:0] REM_FULL = RW'(1) << SH;

  logic [DATA_W-1:0]    a_c;
  logic [PW-1:0]        pos_c;
  logic [PW-1:0]        kf_c;
  logic                 sat_c;
  logic signed [HW-1:0] xe_c;
  logic signed [HW-1:0] lo_sum_c;
  logic signed [HW-1:0] hi_dif_c;
  logic signed [HW-1:0] hsv_c;

  always_comb begin
    // |x|, the most negative value lands on 2^15 as unsigned
    a_c   = in_x[DATA_W-1] ? (~in_x + 1'b1) : in_x;
    pos_c = PW'(a_c) * PW'(SEGMENTS);
    kf_c  = pos_c >> SH;
    sat_c = kf_c >= PW'(SEGMENTS);
    // hard sigmoid range test and rounded numerator
    xe_c     = {{(HW-DATA_W){in_x[DATA_W-1]}}, in_x};
    lo_sum_c = xe_c + HW'(HS_LIM);
    hi_dif_c = HW'(HS_LIM) - xe_c;
    hsv_c    = lo_sum_c + HW'(2);
  end

  // Advance stage 1; beyond the table use the last segment at full span
  always_ff @(posedge clk) begin
    if (ld) begin
      x_r    <= in_x;
      last_r <= in_last;
      k_r    <= sat_c ? IW'(SEGMENTS - 1) : kf_c[IW-1:0];
      rem_r  <= sat_c ? REM_FULL : {1'b0, pos_c[SH-1:0]};
      hsv_r  <= hsv_c[HS_VW-1:0];
      hslo_r <= lo_sum_c[HW-1];
      hshi_r <= hi_dif_c[HW-1];
    end
  end

endmodule

// ===== sv/eau_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_interp
// Stages 2 and 3: segment-end ROM read, slope, interpolation multiply.
// ----------------------------------------------------------------------------
module eau_interp import eau_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int SEGMENTS  = DEF_SEGMENTS
) (
  input  logic                                     clk,
  input  logic                                     ld2,
  input  logic                                     ld3,
  input  mode_t                                    mode,
  input  logic signed [DATA_W-1:0]                 x1,
  input  logic                                     last1,
  input  logic [$clog2(SEGMENTS+1)-1:0]            k1,
  input  logic [FRAC_BITS+3:0]                     rem1,
  input  logic [HS_VW-1:0]                         hsv1,
  input  logic                                     hslo1,
  input  logic                                     hshi1,
  output logic signed [DATA_W-1:0]                 x3_r,
  output logic                                     last3_r,
  output logic                                     hslo3_r,
  output logic                                     hshi3_r,
  output logic [FRAC_BITS:0]                       hsq3_r,
  output logic [FRAC_BITS:0]                       lo3_r,
  output logic [2*FRAC_BITS+4:0]                   prod3_r,
  output logic                                     dneg3_r
);

  localparam int IW  = $clog2(SEGMENTS + 1);
  localparam int TW  = FRAC_BITS + 1;
  localparam int RW  = FRAC_BITS + 4;
  localparam int PRW = TW + RW;
  localparam int HPW = HS_VW + HS_MW;

  logic [TW-1:0] sig_rom  [SEGMENTS+1];
  logic [TW-1:0] tanh_rom [SEGMENTS+1];

  // Segment-end values, worked out at elaboration
  for (genvar g = 0; g <= SEGMENTS; g++) begin : g_rom
    localparam logic [DATA_W-1:0] SIG_E  = eau_tab_entry(SEGMENTS, FRAC_BITS, g, 1'b0);
    localparam logic [DATA_W-1:0] TANH_E = eau_tab_entry(SEGMENTS, FRAC_BITS, g, 1'b1);
    assign sig_rom[g]  = SIG_E[TW-1:0];
    assign tanh_rom[g] = TANH_E[TW-1:0];
  end

  logic [IW-1:0]        k1p_c;
  logic [TW-1:0]        lo_c;
  logic [TW-1:0]        hi_c;
  logic signed [TW:0]   d_c;
  logic [TW-1:0]        dmag_c;

  // Stage 2 registers
  logic signed [DATA_W-1:0] x2_r;
  logic                     last2_r;
  logic                     hslo2_r;
  logic                     hshi2_r;
  logic [HPW-1:0]           hsp2_r;
  logic [TW-1:0]            lo2_r;
  logic [TW-1:0]            dmag2_r;
  logic                     dneg2_r;
  logic [RW-1:0]            rem2_r;

  // Read both ends of the segment and take the slope
  always_comb begin
    k1p_c  = k1 + IW'(1);
    lo_c   = (mode == MODE_TANH) ? tanh_rom[k1]   : sig_rom[k1];
    hi_c   = (mode == MODE_TANH) ? tanh_rom[k1p_c] : sig_rom[k1p_c];
    d_c    = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
    dmag_c = d_c[TW] ? TW'(-d_c) : d_c[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      x2_r    <= x1;
      last2_r <= last1;
      hslo2_r <= hslo1;
      hshi2_r <= hshi1;
      hsp2_r  <= HPW'(hsv1) * HPW'(HS_M);
      lo2_r   <= lo_c;
      dmag2_r <= dmag_c;
      dneg2_r <= d_c[TW];
      rem2_r  <= rem1;
    end
  end

  // Stage 3: slope times offset into the segment; finish divide by five
  always_ff @(posedge clk) begin
    if (ld3) begin
      x3_r    <= x2_r;
      last3_r <= last2_r;
      hslo3_r <= hslo2_r;
      hshi3_r <= hshi2_r;
      hsq3_r  <= hsp2_r[HS_S +: TW];
      lo3_r   <= lo2_r;
      prod3_r <= PRW'(dmag2_r) * PRW'(rem2_r);
      dneg3_r <= dneg2_r;
    end
  end

endmodule

// ===== sv/eau_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_out_stage
// Stage 4: rounding, symmetry for negative input, function select, output register.
// ----------------------------------------------------------------------------
module eau_out_stage import eau_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        ld,
  input  mode_t                       mode,
  input  logic signed [DATA_W-1:0]    x3,
  input  logic                        last3,
  input  logic                        hslo3,
  input  logic                        hshi3,
  input  logic [FRAC_BITS:0]          hsq3,
  input  logic [FRAC_BITS:0]          lo3,
  input  logic [2*FRAC_BITS+4:0]      prod3,
  input  logic                        dneg3,
  output logic signed [DATA_W-1:0]    out_y,
  output logic                        out_last_out
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int SH  = FRAC_BITS + 3;
  localparam int PRW = 2 * FRAC_BITS + 5;
  localparam logic [PRW-1:0]    RND   = PRW'(1) << (SH - 1);
  localparam logic [DATA_W-1:0] ONE_W = DATA_W'(1) << FRAC_BITS;

  logic [PRW-1:0]    sum_c;
  logic [DATA_W-1:0] adj_c;
  logic [DATA_W-1:0] lo_c;
  logic [DATA_W-1:0] t_c;
  logic [DATA_W-1:0] y_c;
  logic              neg_c;

  logic signed [DATA_W-1:0] y_r;
  logic                     last_r;

  always_comb begin
    // round the interpolation step half away from zero
    sum_c = prod3 + RND;
    adj_c = {{(DATA_W-TW){1'b0}}, sum_c[SH +: TW]};
    lo_c  = {{(DATA_W-TW){1'b0}}, lo3};
    t_c   = dneg3 ? (lo_c - adj_c) : (lo_c + adj_c);
    neg_c = x3[DATA_W-1];
    unique case (mode)
      MODE_RELU: y_c = neg_c ? '0 : x3;
      MODE_HSIG: begin
        if (hslo3) begin
          y_c = '0;
        end else if (hshi3) begin
          y_c = ONE_W;
        end else begin
          y_c = {{(DATA_W-TW){1'b0}}, hsq3};
        end
      end
      MODE_SIG:  y_c = neg_c ? (ONE_W - t_c) : t_c;
      MODE_TANH: y_c = neg_c ? (DATA_W'(0) - t_c) : t_c;
    endcase
  end

  // Hold the word until the consumer takes it
  always_ff @(posedge clk) begin
    if (ld) begin
      y_r    <= y_c;
      last_r <= last3;
    end
  end

  assign out_y        = y_r;
  assign out_last_out = last_r;

endmodule

// ===== sv/eau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_checker
// Port-level checks on the activation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "elementwise_activation_unit_defines.svh"

module eau_checker import eau_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_y,
  input logic                     out_last_out,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [CFG_AW-1:0]        paddr,
  input logic [CFG_DW-1:0]        pwdata,
  input logic [CFG_DW-1:0]        prdata,
  input logic                     pready
);

  // A stalled result word holds
  `EAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_y) && $stable(out_last_out), "output word changed while stalled")

  // Reset empties the pipeline
  `EAU_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid right after reset")

  // With the output free, every stage can move, so input is ready
  `EAU_ASSERT_NOW(a_ready_chain, !out_valid || out_ready, in_ready, "input stalled with free output")

  // A mode write reads back in the next cycle
  `EAU_ASSERT_NOW(a_mode_readback, psel && penable && pwrite && pready && (paddr[CFG_AW-1:CFG_IDX_LSB] == REG_MODE) ##1 psel && !pwrite && (paddr[CFG_AW-1:CFG_IDX_LSB] == REG_MODE), prdata[1:0] == $past(pwdata[1:0]), "mode readback mismatch")

endmodule

bind elementwise_activation_unit eau_checker u_eau_checker (.*);

// ===== tb/elementwise_activation_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementwise_activation_unit_tb
// Streams Q4.12 words through all four activation modes under random idling on
// both channels and checks every result against a built-in fixed-point model.
// ----------------------------------------------------------------------------
module elementwise_activation_unit_tb;
  import eau_pkg::*;

  localparam int FRAC         = DEF_FRAC_BITS;
  localparam int SEGS         = DEF_SEGMENTS;
  localparam int REG_SPARE    = 1;
  localparam int SETTLE       = NSTAGE + 4;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_WORDS  = 215;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_DIRECTED = 22;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTS   = 30;

  // Predicts each activated word and holds the results still owed by the block
  class activation_checker;
    mode_t             mode;
    int                sig_lut[SEGS+1];
    int                tanh_lut[SEGS+1];
    logic [DATA_W-1:0] pending_y[$];
    logic              pending_last[$];
    int                errors;
    int                accepted;
    int                checked;
    int                vec_ends;

    function new();
      logic [63:0] term;
      logic [63:0] r;
      logic [63:0] r8;
      logic [63:0] p;
      logic [63:0] q;
      mode     = MODE_RELU;
      errors   = 0;
      accepted = 0;
      checked  = 0;
      vec_ends = 0;
      // exp(-1/SEGS) from its series, then raise to the eighth power
      term = ONE_Q;
      r    = ONE_Q;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        term = term / (64'(SEGS) * 64'(n));
        if (n % 2 == 1) begin
          r = r - term;
        end else begin
          r = r + term;
        end
      end
      r8 = q62_mul(r, r);
      r8 = q62_mul(r8, r8);
      r8 = q62_mul(r8, r8);
      // walk the segment ends: p = exp(-x), q = exp(-2x)
      p = ONE_Q;
      for (int k = 0; k <= SEGS; k++) begin
        q           = q62_mul(p, p);
        sig_lut[k]  = q62_ratio(ONE_Q, ONE_Q + p);
        tanh_lut[k] = q62_ratio(ONE_Q - q, ONE_Q + q);
        p           = q62_mul(p, r8);
      end
    endfunction

    function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
    endfunction

    function int q62_ratio(logic [63:0] num, logic [63:0] den);
      logic [63:0] n;
      logic [63:0] d;
      n = num >> 22;
      d = den >> 22;
      if (d == 64'd0) begin
        d = 64'd1;
      end
      return int'(((n << (FRAC + 1)) + d) / (2 * d));
    endfunction

    // Linear interpolation over |x|, clamped to the last entry from 8.0 up
    function int lerp(bit use_tanh, int a);
      longint span;
      longint pos;
      longint k;
      longint rem;
      longint d;
      longint adj;
      int     lo;
      int     hi;
      span = longint'(8) << FRAC;
      pos  = longint'(a) * SEGS;
      k    = pos / span;
      if (k >= SEGS) begin
        return use_tanh ? tanh_lut[SEGS] : sig_lut[SEGS];
      end
      rem = pos - k * span;
      lo  = use_tanh ? tanh_lut[k] : sig_lut[k];
      hi  = use_tanh ? tanh_lut[k+1] : sig_lut[k+1];
      d   = hi - lo;
      if (d >= 0) begin
        adj = (d * rem + span / 2) / span;
      end else begin
        adj = -((-d * rem + span / 2) / span);
      end
      return lo + int'(adj);
    endfunction

    function logic [DATA_W-1:0] activate(logic signed [DATA_W-1:0] x);
      int xv;
      int a;
      int y;
      int half;
      xv   = x;
      a    = (xv < 0) ? -xv : xv;
      half = 1 << (FRAC - 1);
      case (mode)
        MODE_RELU: begin
          y = (xv < 0) ? 0 : xv;
        end
        MODE_HSIG: begin
          if (xv < -5 * half) begin
            y = 0;
          end else if (xv > 5 * half) begin
            y = 1 << FRAC;
          end else begin
            y = (xv + 5 * half + 2) / 5;
          end
        end
        MODE_SIG: begin
          y = lerp(1'b0, a);
          if (xv < 0) begin
            y = (1 << FRAC) - y;
          end
        end
        default: begin
          y = lerp(1'b1, a);
          if (xv < 0) begin
            y = -y;
          end
        end
      endcase
      return DATA_W'(y);
    endfunction

    function void report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("%0t mismatch: %s", $realtime, what);
      end
    endfunction

    function int pending();
      return pending_y.size();
    endfunction

    function void note_element(logic signed [DATA_W-1:0] x, logic last);
      pending_y.push_back(activate(x));
      pending_last.push_back(last);
      accepted++;
      if (last) begin
        vec_ends++;
      end
    endfunction

    function void check_word(logic signed [DATA_W-1:0] y, logic last);
      logic signed [DATA_W-1:0] want_y;
      logic                     want_last;
      if (pending_y.size() == 0) begin
        report_mismatch($sformatf("result y=%0d with nothing pending", y));
        return;
      end
      want_y    = pending_y.pop_front();
      want_last = pending_last.pop_front();
      if (y !== want_y) begin
        report_mismatch($sformatf("word %0d: y %0d, want %0d (mode %0d)",
                                  checked, y, want_y, mode));
      end
      if (last !== want_last) begin
        report_mismatch($sformatf("word %0d: last_out %b, want %b",
                                  checked, last, want_last));
      end
      checked++;
    endfunction

    function void flush_check();
      while (pending_y.size() != 0) begin
        report_mismatch($sformatf("missing result, y %0d still owed",
                                  $signed(pending_y.pop_front())));
        void'(pending_last.pop_front());
      end
    endfunction
  endclass

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_x         = '0;
  logic                     in_last_in   = 1'b0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic signed [DATA_W-1:0] out_y;
  logic                     out_last_out;
  logic                     psel         = 1'b0;
  logic                     penable      = 1'b0;
  logic                     pwrite       = 1'b0;
  logic [CFG_AW-1:0]        paddr        = '0;
  logic [CFG_DW-1:0]        pwdata       = '0;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;

  activation_checker chk;
  int                cycle_count  = 0;
  int                mode_writes  = 0;
  bit                steady       = 1'b0;
  bit                hold_req     = 1'b0;

  // Directed words: extremes, segment ends and the hard sigmoid knees
  int    dir_x[NUM_DIRECTED] = '{
    0, -1, 32767, -32768,
    -10240, 10240, -10241, 10241, -32768, 32767,
    0, 1024, -1024, 32767, -32768, 512,
    0, -32768, 32767, -1, 3072, -5120
  };
  mode_t dir_mode[NUM_DIRECTED] = '{
    MODE_RELU, MODE_RELU, MODE_RELU, MODE_RELU,
    MODE_HSIG, MODE_HSIG, MODE_HSIG, MODE_HSIG, MODE_HSIG, MODE_HSIG,
    MODE_SIG, MODE_SIG, MODE_SIG, MODE_SIG, MODE_SIG, MODE_SIG,
    MODE_TANH, MODE_TANH, MODE_TANH, MODE_TANH, MODE_TANH, MODE_TANH
  };
  mode_t phase_mode[NUM_PHASES] = '{
    MODE_TANH, MODE_SIG, MODE_HSIG, MODE_RELU, MODE_SIG, MODE_TANH
  };

  elementwise_activation_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x         (in_x),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_y        (out_y),
    .out_last_out (out_last_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[elementwise_activation_unit] ERROR");
      $finish;
    end
  end

  // Note accepted words and check returned ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        chk.note_element(in_x, in_last_in);
      end
      if (out_valid && out_ready) begin
        chk.check_word(out_y, out_last_out);
      end
    end
  end

  // Result side: random stalls, one full-rate stretch and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_element(input logic signed [DATA_W-1:0] x, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_x       <= x;
    in_last_in <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx << CFG_IDX_LSB);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MODE) begin
      chk.mode = mode_t'(data[1:0]);
      mode_writes++;
    end
    @(posedge clk);
  endtask

  task automatic check_mode_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_AW'(int'(REG_MODE) << CFG_IDX_LSB);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(chk.mode)) begin
      chk.report_mismatch($sformatf("mode readback %0h, want %0d", prdata, chk.mode));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every owed result is back, then let the pipe go quiet
  task automatic wait_drained();
    // wait for a clock edge first so a word taken at this edge is already counted
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_x();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 35) begin
      v = $urandom();
    end else if (sel < 60) begin
      v = $urandom_range(24576) - 12288;
    end else if (sel < 80) begin
      v = $urandom_range(SEGS) * (8 << FRAC) / SEGS + $urandom_range(2) - 1;
      if ($urandom_range(1) == 1) begin
        v = -v;
      end
    end else if (sel < 90) begin
      v = 5 * (1 << (FRAC - 1)) + $urandom_range(4) - 2;
      if ($urandom_range(1) == 1) begin
        v = -v;
      end
    end else begin
      case ($urandom_range(5))
        0: v = -32768;
        1: v = 32767;
        2: v = -32767;
        3: v = 0;
        4: v = -1;
        default: v = 1;
      endcase
    end
    return DATA_W'(v);
  endfunction

  initial begin
    chk = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_mode_readback();

    // Directed words, mode switched with all upper data bits set
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (i == 0 || dir_mode[i] != dir_mode[i-1]) begin
        in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_MODE, 32'hFFFF_FFFC | CFG_DW'(dir_mode[i]));
        check_mode_readback();
      end
      send_element(DATA_W'(dir_x[i]), i[0]);
    end

    // Random phases, one per mode setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      write_reg(REG_SPARE, $urandom());
      write_reg(REG_MODE, ($urandom() & 32'hFFFF_FFFC) | CFG_DW'(phase_mode[ph]));
      check_mode_readback();
      steady = (ph == 1);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_WORDS) send_element(pick_x(), $urandom_range(7) == 0);
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    wait_drained();
    chk.flush_check();
    $display("run: %0d words accepted, %0d checked, %0d vector ends, %0d mode writes",
             chk.accepted, chk.checked, chk.vec_ends, mode_writes);
    $display("run: all four modes, one full-rate stretch, one %0d-cycle output hold",
             HOLD_CYCLES);
    if (chk.errors == 0) begin
      $display("[elementwise_activation_unit] OK");
    end else begin
      $display("%0d mismatches", chk.errors);
      $display("[elementwise_activation_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== elementwise_activation_unit.f =====
+incdir+sv
sv/eau_pkg.sv
sv/eau_cfg_regs.sv
sv/eau_pipe_ctrl.sv
sv/eau_seg_front.sv
sv/eau_interp.sv
sv/eau_out_stage.sv
sv/elementwise_activation_unit.sv
sv/eau_checker.sv
tb/elementwise_activation_unit_tb.sv
